// ===== sv/vuc_pkg.sv =====
`timescale 1ns / 1ps

package vuc_pkg;

    localparam int unsigned AMOUNT_W = 63;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned CFG_W    = 31;
    localparam int unsigned OPND_W   = 61;   // widest multiplier / divisor operand
    localparam int unsigned PROD_W   = 124;  // 63 x 61 bit product
    localparam int unsigned HI_W     = PROD_W - VALUE_W;
    localparam int unsigned NCELLS   = VALUE_W;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [1:0] UNIT_FRAMES = 2'd0;
    localparam logic [1:0] UNIT_BYTES  = 2'd1;
    localparam logic [1:0] UNIT_TIME   = 2'd2;
    localparam logic [1:0] UNIT_OTHER  = 2'd3;

    localparam logic [1:0] REG_BPP     = 2'd0;
    localparam logic [1:0] REG_RATE_N  = 2'd1;
    localparam logic [1:0] REG_RATE_D  = 2'd2;

    typedef enum logic [2:0] {
        KIND_PASS  = 3'd0,
        KIND_MULLO = 3'd1,
        KIND_DIV   = 3'd2,
        KIND_SAT   = 3'd3,
        KIND_FAIL  = 3'd4
    } t_kind;

    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic [OPND_W-1:0]   divisor;
    } t_side;

    typedef struct packed {
        t_side               side;
        logic [OPND_W-1:0]   rem;
        logic [VALUE_W-1:0]  lo;
        logic [VALUE_W-1:0]  quo;
    } t_div;

endpackage

// ===== sv/vuc_mul.sv =====
`timescale 1ns / 1ps

module vuc_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  vuc_pkg::t_side                i_side,
    input  logic [vuc_pkg::AMOUNT_W-1:0]  i_a,
    input  logic [vuc_pkg::OPND_W-1:0]    i_b,
    output vuc_pkg::t_side                o_side,
    output logic [vuc_pkg::PROD_W-1:0]    o_prod
);

    vuc_pkg::t_side r_side1, r_side2, r_side3;
    logic [63:0] r_ll;
    logic [60:0] r_lh;
    logic [62:0] r_hl;
    logic [59:0] r_hh;
    logic [63:0] r_ll2, r_mid;
    logic [59:0] r_hh2;
    logic [vuc_pkg::PROD_W-1:0] r_prod;

    // four partial products of the low 32-bit and the upper operand slices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
            r_side3.valid <= 1'b0;
        end else if (i_en) begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
            r_lh  <= 61'(i_a[31:0]) * 61'(i_b[60:32]);
            r_hl  <= 63'(i_a[62:32]) * 63'(i_b[31:0]);
            r_hh  <= 60'(i_a[62:32]) * 60'(i_b[60:32]);
            r_mid <= 64'(r_lh) + 64'(r_hl);
            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
            r_prod <= {r_hh2, r_ll2} + {28'd0, r_mid, 32'd0};
        end
    end

    assign o_side = r_side3;
    assign o_prod = r_prod;

endmodule

// ===== sv/vuc_div_cell.sv =====
`timescale 1ns / 1ps

module vuc_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  vuc_pkg::t_div i_div,
    output vuc_pkg::t_div o_div
);

    vuc_pkg::t_div r_div, n_div;
    logic [vuc_pkg::OPND_W:0] w_sh;
    logic [vuc_pkg::OPND_W:0] w_diff;
    logic                     w_ge;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_sh   = {i_div.rem, i_div.lo[vuc_pkg::VALUE_W-1]};
        w_diff = w_sh - {1'b0, i_div.side.divisor};
        w_ge   = (w_sh >= {1'b0, i_div.side.divisor});
        n_div      = i_div;
        n_div.rem  = w_ge ? w_diff[vuc_pkg::OPND_W-1:0] : w_sh[vuc_pkg::OPND_W-1:0];
        n_div.lo   = {i_div.lo[vuc_pkg::VALUE_W-2:0], 1'b0};
        n_div.quo  = {i_div.quo[vuc_pkg::VALUE_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.side.valid <= 1'b0;
        end else if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== sv/video_unit_converter.sv =====
`timescale 1ns / 1ps
// Path: stage 1, multiplier, divider load, divider cells, output register.
// Throughput: one item per cycle; the whole pipeline advances together and holds only
// while a result sits in the output register and the master side is not ready.
// Reset: synchronous, active low; clears all valid flags and the three configuration
// registers to zero.
module video_unit_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // [62:0] amount, [63] zero
    input  logic [3:0]   i_s_tuser,   // [1:0] source_unit, [3:2] target_unit
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // [63:0] converted
    output logic         o_m_tuser    // [0] success
);

    localparam int unsigned AW = vuc_pkg::AMOUNT_W;
    localparam int unsigned OW = vuc_pkg::OPND_W;
    localparam int unsigned VW = vuc_pkg::VALUE_W;
    localparam int unsigned N  = vuc_pkg::NCELLS;

    // configuration registers
    logic [vuc_pkg::CFG_W-1:0] r_bpp, r_rate_n, r_rate_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= '0;
            r_rate_n <= '0;
            r_rate_d <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vuc_pkg::REG_BPP:    r_bpp    <= i_cfg_data;
                vuc_pkg::REG_RATE_N: r_rate_n <= i_cfg_data;
                vuc_pkg::REG_RATE_D: r_rate_d <= i_cfg_data;
                default: ;  // unused index, drop the write
            endcase
        end
    end

    // single pipeline enable: advance unless the output holds an untaken item
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ---------------- stage 1: decode the unit pair, pick operands ----------
    logic [1:0]     w_src, w_dst;
    logic [AW-1:0]  w_amount;
    logic [OW-1:0]  w_ns_den;
    vuc_pkg::t_side n_side0, r_side0;
    logic [OW-1:0]  n_b, r_b;
    logic [AW-1:0]  r_a;

    assign w_src    = i_s_tuser[1:0];
    assign w_dst    = i_s_tuser[3:2];
    assign w_amount = i_s_tdata[AW-1:0];
    assign w_ns_den = OW'(r_rate_d) * OW'(vuc_pkg::NS_PER_SEC);

    always_comb begin
        n_side0.valid   = i_s_tvalid;
        n_side0.kind    = vuc_pkg::KIND_FAIL;
        n_side0.value   = {1'b0, w_amount};
        n_side0.divisor = OW'(1);
        n_b             = OW'(1);
        if (w_src == w_dst) begin
            n_side0.kind = vuc_pkg::KIND_PASS;
        end else if (w_src == vuc_pkg::UNIT_BYTES && w_dst == vuc_pkg::UNIT_FRAMES
                     && r_bpp != '0) begin
            // divide by the picture size: amount * 1 / bpp
            n_side0.kind    = vuc_pkg::KIND_DIV;
            n_side0.divisor = OW'(r_bpp);
        end else if (w_src == vuc_pkg::UNIT_FRAMES && w_dst == vuc_pkg::UNIT_BYTES
                     && r_bpp != '0) begin
            n_side0.kind = vuc_pkg::KIND_MULLO;
            n_b          = OW'(r_bpp);
        end else if (w_src == vuc_pkg::UNIT_FRAMES && w_dst == vuc_pkg::UNIT_TIME
                     && r_rate_n != '0) begin
            n_side0.kind    = vuc_pkg::KIND_DIV;
            n_b             = w_ns_den;
            n_side0.divisor = OW'(r_rate_n);
        end else if (w_src == vuc_pkg::UNIT_TIME && w_dst == vuc_pkg::UNIT_FRAMES
                     && r_rate_d != '0) begin
            n_side0.kind    = vuc_pkg::KIND_DIV;
            n_b             = OW'(r_rate_n);
            n_side0.divisor = w_ns_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0.valid <= 1'b0;
        end else if (w_en) begin
            r_side0 <= n_side0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= w_amount;
            r_b <= n_b;
        end
    end

    // ---------------- stages 2 to 4: exact 124-bit product ------------------
    vuc_pkg::t_side               w_mside;
    logic [vuc_pkg::PROD_W-1:0]   w_prod;

    vuc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (r_side0),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_side  (w_mside),
        .o_prod  (w_prod)
    );

    // ---------------- stage 5: overflow check, load the divider -------------
    logic [vuc_pkg::HI_W-1:0] w_hi;
    vuc_pkg::t_div            n_div0, r_div0;

    assign w_hi = w_prod[vuc_pkg::PROD_W-1:VW];

    always_comb begin
        n_div0.side = w_mside;
        n_div0.rem  = OW'(w_hi);
        n_div0.lo   = w_prod[VW-1:0];
        n_div0.quo  = '0;
        case (w_mside.kind)
            vuc_pkg::KIND_MULLO: begin
                // frames to bytes keeps the low 64 bits of the product
                n_div0.side.kind  = vuc_pkg::KIND_PASS;
                n_div0.side.value = w_prod[VW-1:0];
            end
            vuc_pkg::KIND_DIV: begin
                // high half not below the divisor: quotient would overflow
                if ({1'b0, w_hi} >= w_mside.divisor) begin
                    n_div0.side.kind = vuc_pkg::KIND_SAT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div0.side.valid <= 1'b0;
        end else if (w_en) begin
            r_div0 <= n_div0;
        end
    end

    // ---------------- divider row: one quotient bit per cell ----------------
    vuc_pkg::t_div w_chain [N+1];

    assign w_chain[0] = r_div0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        vuc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_chain[g]),
            .o_div   (w_chain[g+1])
        );
    end

    // ---------------- output register ---------------------------------------
    logic            r_out_valid;
    logic [VW-1:0]   r_out_value, n_out_value;
    logic            r_out_ok, n_out_ok;
    vuc_pkg::t_div   w_last;

    assign w_last = w_chain[N];

    always_comb begin
        n_out_value = '0;
        n_out_ok    = 1'b0;
        case (w_last.side.kind)
            vuc_pkg::KIND_PASS: begin
                n_out_value = w_last.side.value;
                n_out_ok    = 1'b1;
            end
            vuc_pkg::KIND_DIV: begin
                n_out_value = w_last.quo;
                n_out_ok    = 1'b1;
            end
            vuc_pkg::KIND_SAT: begin
                n_out_value = '1;
                n_out_ok    = 1'b1;
            end
            default: ;  // failed conversion reports zero
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_value <= n_out_value;
            r_out_ok    <= n_out_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_ok;

endmodule

// ===== sv/vuc_checker.sv =====
`timescale 1ns / 1ps

module vuc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a stalled result item stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result item changed while stalled");

    // a failed conversion carries zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 64'd0)
        else $error("failed conversion with nonzero value");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // input side stalls only behind an untaken result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow the output stall");

endmodule

bind video_unit_converter vuc_checker u_vuc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== sim/video_unit_converter_checker.sv =====
`timescale 1ns / 1ps

module video_unit_converter_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_s_tdata,
    input  logic [3:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } t_conv;

    logic [30:0] r_bpp, r_rate_n, r_rate_d;
    t_conv       conv_q[$];

    // floor(a * b / d), saturated when the quotient exceeds 64 bits
    function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                    logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = {64'd0, a} * {64'd0, b};
        quo  = prod / {64'd0, d};
        if (quo[127:64] != 0) return '1;
        return quo[63:0];
    endfunction

    function automatic t_conv convert(logic [1:0] src, logic [1:0] dst, logic [62:0] amt);
        t_conv r;
        logic [63:0] ns_den;
        r = '0;
        ns_den = 64'(vuc_pkg::NS_PER_SEC) * 64'(r_rate_d);
        if (src == dst) begin
            r = '{{1'b0, amt}, 1'b1};
        end else if (src == vuc_pkg::UNIT_BYTES && dst == vuc_pkg::UNIT_FRAMES
                     && r_bpp != 0) begin
            r = '{{1'b0, amt} / 64'(r_bpp), 1'b1};
        end else if (src == vuc_pkg::UNIT_FRAMES && dst == vuc_pkg::UNIT_BYTES
                     && r_bpp != 0) begin
            r = '{{1'b0, amt} * 64'(r_bpp), 1'b1};
        end else if (src == vuc_pkg::UNIT_FRAMES && dst == vuc_pkg::UNIT_TIME
                     && r_rate_n != 0) begin
            r = '{scaled_quotient({1'b0, amt}, ns_den, 64'(r_rate_n)), 1'b1};
        end else if (src == vuc_pkg::UNIT_TIME && dst == vuc_pkg::UNIT_FRAMES
                     && r_rate_d != 0) begin
            r = '{scaled_quotient({1'b0, amt}, 64'(r_rate_n), ns_den), 1'b1};
        end
        return r;
    endfunction

    assign o_pending = conv_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_conv want;
        if (!i_rst_n) begin
            r_bpp <= '0;
            r_rate_n <= '0;
            r_rate_d <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vuc_pkg::REG_BPP:    r_bpp <= i_cfg_data;
                    vuc_pkg::REG_RATE_N: r_rate_n <= i_cfg_data;
                    vuc_pkg::REG_RATE_D: r_rate_d <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                conv_q.push_back(convert(i_s_tuser[1:0], i_s_tuser[3:2], i_s_tdata[62:0]));
            if (i_m_tvalid && i_m_tready) begin
                if (conv_q.size() == 0) begin
                    $display("%0t: unexpected item: value %h ok %b", $time,
                             i_m_tdata, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = conv_q.pop_front();
                    if (want.value !== i_m_tdata || want.ok !== i_m_tuser) begin
                        $display("%0t: mismatch: expected %h/%b, got %h/%b", $time,
                                 want.value, want.ok, i_m_tdata, i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/video_unit_converter_tb.sv =====
`timescale 1ns / 1ps

module video_unit_converter_tb;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_idx = '0;
    logic [30:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    int           errors;
    int           pending;
    bit           calm = 1'b0;   // suppress idling on both sides

    video_unit_converter DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    video_unit_converter_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard limit on the run.
    initial begin
        #30ms;
        $display("video_unit_converter_tb: done, errors");
        $finish;
    end

    // Receiver: drop ready in about a quarter of cycles unless calm.
    always @(negedge clk) begin
        m_tready <= calm || ($urandom_range(99) >= 26);
    end

    // Write one register at a falling edge, held for one cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one item and hold it until accepted; valid stays high into the next item.
    task automatic send_conv(input logic [1:0] src, input logic [1:0] dst,
                             input logic [62:0] amt);
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, amt};
        s_tuser <= {dst, src};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until every expected item has come back, then let the pipeline empty.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [62:0] rand_amount();
        logic [62:0] a;
        a = 63'({$urandom, $urandom});
        case ($urandom_range(5))
            0: a = a & 63'hFFFF;
            1: a = a & 63'hFFFF_FFFF;
            2: a = '1;
            3: a = '0;
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [30:0] rand_cfg();
        logic [30:0] v;
        v = 31'($urandom);
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = 31'($urandom_range(1, 3));
            3: v = 31'($urandom_range(1, 120));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [1:0] src, dst;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: registers at reset value zero, every divisor path fails.
        send_conv(vuc_pkg::UNIT_BYTES, vuc_pkg::UNIT_FRAMES, 63'd1000);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_BYTES, 63'd5);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_TIME, 63'd5);
        send_conv(vuc_pkg::UNIT_TIME, vuc_pkg::UNIT_FRAMES, 63'd5);
        send_conv(vuc_pkg::UNIT_OTHER, vuc_pkg::UNIT_OTHER, '1);
        drain();

        // Typical video settings.
        write_reg(vuc_pkg::REG_BPP, 31'd3110400);
        write_reg(vuc_pkg::REG_RATE_N, 31'd30000);
        write_reg(vuc_pkg::REG_RATE_D, 31'd1001);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_FRAMES, '0);
        send_conv(vuc_pkg::UNIT_BYTES, vuc_pkg::UNIT_BYTES, '1);
        send_conv(vuc_pkg::UNIT_TIME, vuc_pkg::UNIT_TIME, 63'd77);
        send_conv(vuc_pkg::UNIT_BYTES, vuc_pkg::UNIT_FRAMES, 63'd6220801);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_BYTES, '1);   // wraps modulo 2^64
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_TIME, 63'd30000);
        send_conv(vuc_pkg::UNIT_TIME, vuc_pkg::UNIT_FRAMES, 63'd1001000000);
        send_conv(vuc_pkg::UNIT_BYTES, vuc_pkg::UNIT_TIME, 63'd9);  // unsupported pair
        send_conv(vuc_pkg::UNIT_TIME, vuc_pkg::UNIT_BYTES, 63'd9);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_OTHER, 63'd9);
        send_conv(vuc_pkg::UNIT_OTHER, vuc_pkg::UNIT_FRAMES, 63'd9);
        drain();

        // Extremes: largest settings and amounts; a quotient overflow saturates.
        write_reg(vuc_pkg::REG_BPP, '1);
        write_reg(vuc_pkg::REG_RATE_N, 31'd1);
        write_reg(vuc_pkg::REG_RATE_D, '1);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_TIME, '1);
        send_conv(vuc_pkg::UNIT_TIME, vuc_pkg::UNIT_FRAMES, '1);
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_BYTES, '1);
        send_conv(vuc_pkg::UNIT_BYTES, vuc_pkg::UNIT_FRAMES, '1);
        drain();
        write_reg(vuc_pkg::REG_RATE_N, '1);
        write_reg(vuc_pkg::REG_RATE_D, '0);
        send_conv(vuc_pkg::UNIT_TIME, vuc_pkg::UNIT_FRAMES, '1);    // zero denominator fails
        send_conv(vuc_pkg::UNIT_FRAMES, vuc_pkg::UNIT_TIME, '1);
        drain();

        // Random phases, each with new register settings.
        for (int ph = 0; ph < 19; ph++) begin
            write_reg(vuc_pkg::REG_BPP, rand_cfg());
            write_reg(vuc_pkg::REG_RATE_N, rand_cfg());
            write_reg(vuc_pkg::REG_RATE_D, rand_cfg());
            calm = (ph == 7);
            for (int n = 0; n < 50; n++) begin
                src = 2'($urandom);
                dst = 2'($urandom);
                // favor the conversions that do arithmetic
                if ($urandom_range(99) < 70) begin
                    case ($urandom_range(3))
                        0: begin
                            src = vuc_pkg::UNIT_BYTES;
                            dst = vuc_pkg::UNIT_FRAMES;
                        end
                        1: begin
                            src = vuc_pkg::UNIT_FRAMES;
                            dst = vuc_pkg::UNIT_BYTES;
                        end
                        2: begin
                            src = vuc_pkg::UNIT_FRAMES;
                            dst = vuc_pkg::UNIT_TIME;
                        end
                        default: begin
                            src = vuc_pkg::UNIT_TIME;
                            dst = vuc_pkg::UNIT_FRAMES;
                        end
                    endcase
                end
                send_conv(src, dst, rand_amount());
            end
            drain();
            calm = 1'b0;
        end

        if (errors == 0) begin
            $display("video_unit_converter_tb: done, clean");
        end else begin
            $display("video_unit_converter_tb: done, errors");
        end
        $finish;
    end

endmodule
